// ----- rtl/spag_pkg.sv -----
// Shared widths, constants and the quarter-wave sine entry function for the
// sine phase accumulator generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spag_pkg;

	localparam int unsigned FIELD_W             = 16;
	localparam int unsigned IN_DATA_W           = 2 * FIELD_W;
	localparam int unsigned OUT_DATA_W          = 16;
	localparam int unsigned RATE_W              = 16;
	localparam logic [RATE_W-1:0] RATE_RESET    = 16'd8000;
	localparam int unsigned AMAG_W              = FIELD_W + 1;
	localparam int unsigned SINE_W              = 17;
	localparam int unsigned SINE_FRAC           = 15;
	localparam int unsigned DIV_STEP_BITS       = 4;
	localparam int unsigned QUEUE_DEPTH         = 2;
	localparam int unsigned BACK_STAGES         = 4;
	localparam int unsigned PHASE_BITS_DEF      = 32;
	localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
	localparam longint unsigned HALF_PI_Q30     = 64'd1686629713;

	// Entry k of the quarter-wave table, Q1.15, from an odd series to x^11
	// in Q2.30. Only ever called with constant arguments.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
		input int unsigned abits);
		longint unsigned t;
		longint unsigned t2;
		longint unsigned term;
		longint          sum;
		longint unsigned r;
		t    = (HALF_PI_Q30 * longint'(k)) >> abits;
		t2   = (t * t) >> 30;
		term = t;
		sum  = longint'(t);
		term = ((term * t2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * t2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * t2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * t2) >> 30) / 72;
		sum  = sum + longint'(term);
		term = ((term * t2) >> 30) / 110;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		r = (longint'(sum) + 64'd16384) >> 15;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return r[SINE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/spag_queue.sv -----
// Short FIFO between the step divider and the synthesis pipeline.
// Depends on spag_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module spag_queue import spag_pkg::*; #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/spag_front.sv -----
// Front end: takes request beats, holds the sample rate and works out the
// phase step with a radix-16 long divider. Depends on spag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spag_front import spag_pkg::*; #(
	parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [IN_DATA_W-1:0]         s_tdata,
	input  logic                         s_tlast,
	input  logic                         cfg_valid,
	input  logic [RATE_W-1:0]            cfg_data,
	output logic                         push,
	output logic [PHASE_BITS+AMAG_W:0]   push_data,
	input  logic                         full
);

	localparam int unsigned DIV_ITER =
		(FIELD_W + PHASE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int unsigned DVD_W = DIV_ITER * DIV_STEP_BITS;
	localparam int unsigned CNT_W = $clog2(DIV_ITER);

	typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_PUSH} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [RATE_W-1:0]     rate_q;
	logic [DVD_W-1:0]      dvd_q;
	logic [RATE_W-1:0]     rem_q;
	logic [PHASE_BITS-1:0] quo_q;
	logic                  fneg_q;
	logic                  rzero_q;
	logic [AMAG_W-1:0]     amag_q;
	logic                  last_q;

	logic [FIELD_W-1:0]    freq;
	logic [FIELD_W-1:0]    ampl;
	logic [FIELD_W-1:0]    fmag;
	logic [AMAG_W-1:0]     amag;
	logic [DVD_W-1:0]      dvd_n;
	logic [RATE_W-1:0]     rem_n;
	logic [PHASE_BITS-1:0] quo_n;
	logic [PHASE_BITS-1:0] step_mag;
	logic [PHASE_BITS-1:0] step;

	assign freq = s_tdata[FIELD_W-1:0];
	assign ampl = s_tdata[IN_DATA_W-1:FIELD_W];
	assign fmag = freq[FIELD_W-1] ? (~freq + 1'b1) : freq;
	assign amag = ampl[FIELD_W-1] ? (AMAG_W'(1) << FIELD_W) - {1'b0, ampl} : {1'b0, ampl};

	// Restoring division, DIV_STEP_BITS quotient bits per cycle. Only the low
	// PHASE_BITS of the quotient are kept: the step wraps anyway.
	always_comb begin
		logic [RATE_W:0] part;
		dvd_n = dvd_q;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int j = 0; j < DIV_STEP_BITS; j++) begin
			part  = {rem_n, dvd_n[DVD_W-1]};
			dvd_n = {dvd_n[DVD_W-2:0], 1'b0};
			if (part >= {1'b0, rate_q}) begin
				rem_n = RATE_W'(part - {1'b0, rate_q});
				quo_n = {quo_n[PHASE_BITS-2:0], 1'b1};
			end else begin
				rem_n = part[RATE_W-1:0];
				quo_n = {quo_n[PHASE_BITS-2:0], 1'b0};
			end
		end
	end

	assign step_mag  = rzero_q ? '0 : quo_q;
	assign step      = fneg_q ? (~step_mag + 1'b1) : step_mag;
	assign s_tready  = (state_q == ST_IDLE);
	assign push      = (state_q == ST_PUSH) && !full;
	assign push_data = {step, amag_q, last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rate_q  <= RATE_RESET;
		end else begin
			if (cfg_valid) begin
				rate_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIVIDE;
						cnt_q   <= CNT_W'(DIV_ITER - 1);
					end
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dvd_q   <= DVD_W'(fmag) << PHASE_BITS;
			rem_q   <= '0;
			quo_q   <= '0;
			fneg_q  <= freq[FIELD_W-1];
			rzero_q <= (rate_q == '0);
			amag_q  <= amag;
			last_q  <= s_tlast;
		end else if (state_q == ST_DIVIDE) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/spag_back.sv -----
// Back end: phase accumulator, quarter-wave table lookup, amplitude scaling
// and the output register. Depends on spag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spag_back import spag_pkg::*; #(
	parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
	parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       pop,
	input  logic [PHASE_BITS+AMAG_W:0] pop_data,
	input  logic                       empty,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast
);

	localparam int unsigned QLEN   = 1 << TABLE_ADDR_BITS;
	localparam int unsigned ADDR_W = TABLE_ADDR_BITS + 1;
	localparam int unsigned PROD_W = AMAG_W + SINE_W;

	logic [SINE_W-1:0] rom_w [QLEN+1];

	for (genvar k = 0; k <= QLEN; k++) begin : g_rom
		assign rom_w[k] = sine_entry(k, TABLE_ADDR_BITS);
	end

	logic                       en;
	logic [PHASE_BITS-1:0]      step;
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS-1:0] idx;
	logic [ADDR_W-1:0]          addr;

	logic [PHASE_BITS-1:0]      phase_q;
	logic                       valid_s1;
	logic [AMAG_W-1:0]          amag_s1;
	logic                       last_s1;
	logic                       valid_s2;
	logic [SINE_W-1:0]          sine_s2;
	logic                       neg_s2;
	logic [AMAG_W-1:0]          amag_s2;
	logic                       last_s2;
	logic                       valid_s3;
	logic [PROD_W-1:0]          prod_s3;
	logic                       neg_s3;
	logic                       last_s3;
	logic                       out_valid_q;
	logic [OUT_DATA_W-1:0]      out_data_q;
	logic                       out_last_q;

	logic [PROD_W-SINE_FRAC-1:0] rr;
	logic [AMAG_W-1:0]           nmag;
	logic [OUT_DATA_W-1:0]       val;

	// Whole pipeline moves together; it only holds while a result waits.
	assign en   = !out_valid_q || m_tready;
	assign pop  = en && !empty;
	assign step = pop_data[PHASE_BITS+AMAG_W -: PHASE_BITS];

	// phase_q already includes the item sitting in s1
	assign quad = phase_q[PHASE_BITS-1 -: 2];
	assign idx  = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];
	assign addr = quad[0] ? (ADDR_W'(QLEN) - {1'b0, idx}) : {1'b0, idx};

	assign rr   = prod_s3[PROD_W-1:SINE_FRAC];
	assign nmag = (rr > (PROD_W-SINE_FRAC)'(32768)) ? AMAG_W'(32768) : rr[AMAG_W-1:0];

	always_comb begin
		if (neg_s3) begin
			val = OUT_DATA_W'(~nmag + 1'b1);
		end else if (rr > (PROD_W-SINE_FRAC)'(32767)) begin
			val = OUT_DATA_W'(32767);
		end else begin
			val = rr[OUT_DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (pop) begin
				phase_q <= phase_q + step;
			end
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			amag_s1    <= pop_data[AMAG_W:1];
			last_s1    <= pop_data[0];
			sine_s2    <= rom_w[addr];
			neg_s2     <= quad[1];
			amag_s2    <= amag_s1;
			last_s2    <= last_s1;
			prod_s3    <= amag_s2 * sine_s2;
			neg_s3     <= neg_s2;
			last_s3    <= last_s2;
			out_data_q <= val;
			out_last_q <= last_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/sine_phase_accumulator_generator.sv -----
// Direct digital synthesis sine source, one sample per request beat.
// Request beat on s_*: frequency (signed Hz) and amplitude (signed, magnitude
// used) in s_tdata, frame mark in s_tlast. Sample beat on m_*: signed sample
// in m_tdata, frame mark echoed on m_tlast. cfg_* writes the sample rate in
// Hz; cfg_ready is always high and writes belong in idle periods.
// The front's divider, which retires four quotient bits a cycle, sets the
// request rate: a new request is taken only after the step of the last one
// has been pushed into the queue. A request's step then passes through the
// queue and the back end's s1, s2 and s3 stages into the output register.
// A two-beat queue sits between the divider and the synthesis pipeline, so
// requests keep being taken while m_tready is low until the queue fills and
// the front holds a finished step; after that s_tready stays low. The four
// pipeline stages stall together once a sample waits in the output register.
// Reset clears the phase to zero and sets the sample rate to 8000 Hz. The
// phase persists across frames; tlast never touches it.
// Depends on spag_pkg, spag_front, spag_queue, spag_back.
`timescale 1ns / 1ps
`default_nettype none

module sine_phase_accumulator_generator import spag_pkg::*; #(
	parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
	parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] frequency, [31:16] amplitude
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] sample
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [RATE_W-1:0]     cfg_data
);

	localparam int unsigned Q_W = PHASE_BITS + AMAG_W + 1;

	logic           push;
	logic [Q_W-1:0] push_data;
	logic           full;
	logic           pop;
	logic [Q_W-1:0] pop_data;
	logic           empty;

	assign cfg_ready = 1'b1;

	spag_front #(
		.PHASE_BITS (PHASE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	spag_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	spag_back #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ----- rtl/spag_checker.sv -----
// Port-level checks for the sine phase accumulator generator, bound to the
// top level below. Depends on spag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spag_checker import spag_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// front holding one, the queue, and the back stages
	localparam int unsigned MAX_INFLIGHT = 1 + QUEUE_DEPTH + BACK_STAGES;
	localparam int unsigned CNT_W        = $clog2(MAX_INFLIGHT + 2);

	logic             in_beat;
	logic             out_beat;
	logic [CNT_W-1:0] inflight_q;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_beat && !out_beat) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("sample beat withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("sample beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("request taken while divider busy");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != '0)
		else $error("sample beat without a pending request");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(MAX_INFLIGHT))
		else $error("more requests in flight than storage allows");

endmodule

bind sine_phase_accumulator_generator spag_checker u_spag_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
